// File: rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and codes shared by the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic CFG_SEARCH_LOW  = 1'b0;
  localparam logic CFG_SEARCH_HIGH = 1'b1;

  localparam logic [IDX_W-1:0] SEARCH_LOW_RESET  = 4'd0;
  localparam logic [IDX_W-1:0] SEARCH_HIGH_RESET = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  typedef struct packed {
    logic load_en;
    logic search_start;
    logic probe_step;
    logic result_load;
    logic result_probe;
  } dp_cmd_t;

  typedef struct packed {
    logic start_empty;
    logic probe_hit;
    logic probe_last;
  } dp_status_t;

endpackage

// File: rtl/core/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: transaction handshakes, search sequencing and result valid.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  req_type,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  stbs_pkg::dp_status_t  status,
  output stbs_pkg::dp_cmd_t     cmd
);
  import stbs_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (req_type == REQ_LOAD) begin
            cmd.load_en     = 1'b1;
            cmd.result_load = 1'b1;
          end else begin
            cmd.search_start = 1'b1;
            if (status.start_empty) begin
              cmd.result_load = 1'b1;
            end else begin
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (status.probe_hit || status.probe_last) begin
          if (out_free) begin
            cmd.result_load  = 1'b1;
            cmd.result_probe = 1'b1;
            state_next       = ST_IDLE;
          end
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.result_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/stbs_dpath.sv
// ----------------------------------------------------------------------------
// stbs_dpath
// Datapath: window registers, table RAM, probe compare and result register.
// ----------------------------------------------------------------------------
module stbs_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [stbs_pkg::IDX_W-1:0]       cfg_data,
  input  logic [stbs_pkg::IDX_W-1:0]       entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] value,
  input  stbs_pkg::dp_cmd_t                cmd,
  output stbs_pkg::dp_status_t             status,
  output logic                             found,
  output logic [stbs_pkg::IDX_W-1:0]       position
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [IDX_W-1:0]        search_low;
  logic [IDX_W-1:0]        search_high;
  logic signed [KEY_W-1:0] key;
  logic [IDX_W-1:0]        lo;
  logic [IDX_W-1:0]        hi;
  logic [IDX_W-1:0]        mid;
  logic                    mid_oob;

  logic [IDX_W:0]          cfg_sum;
  logic [IDX_W-1:0]        lo_step;
  logic [IDX_W-1:0]        hi_step;
  logic [IDX_W:0]          step_sum;
  logic [IDX_W-1:0]        mid_next;
  logic                    mid_oob_next;
  logic [AW+IDX_W-1:0]     raddr_ext;
  logic [AW+IDX_W-1:0]     waddr_ext;
  logic                    ram_we;
  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] probe;
  logic                    key_lt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_low  <= SEARCH_LOW_RESET;
      search_high <= SEARCH_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_LOW:  search_low  <= cfg_data;
        CFG_SEARCH_HIGH: search_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_sum = {1'b0, search_low} + {1'b0, search_high};

  // probe compare
  assign probe  = mid_oob ? '0 : $signed(rdata);
  assign key_lt = key < probe;

  assign status.start_empty = search_low > search_high;
  assign status.probe_hit   = key == probe;
  assign status.probe_last  = key_lt ? (lo == mid) : (mid == hi);

  // next window
  always_comb begin
    lo_step = lo;
    hi_step = hi;
    if (key_lt) begin
      hi_step = mid - 4'd1;
    end else begin
      lo_step = mid + 4'd1;
    end
  end

  assign step_sum = {1'b0, lo_step} + {1'b0, hi_step};

  always_comb begin
    if (cmd.search_start) begin
      mid_next = cfg_sum[IDX_W:1];
    end else if (cmd.probe_step) begin
      mid_next = step_sum[IDX_W:1];
    end else begin
      mid_next = mid;
    end
  end

  assign mid_oob_next = 32'(mid_next) >= 32'(TABLE_DEPTH);
  assign raddr_ext    = {{AW{1'b0}}, mid_next};
  assign waddr_ext    = {{AW{1'b0}}, entry_index};
  assign ram_we       = cmd.load_en && (32'(entry_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (value),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    mid     <= mid_next;
    mid_oob <= mid_oob_next;
    if (cmd.search_start) begin
      key <= value;
      lo  <= search_low;
      hi  <= search_high;
    end else if (cmd.probe_step) begin
      lo <= lo_step;
      hi <= hi_step;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (cmd.result_probe) begin
        found    <= status.probe_hit;
        position <= status.probe_hit ? mid : '0;
      end else if (cmd.load_en) begin
        found    <= 1'b0;
        position <= entry_index;
      end else begin
        found    <= 1'b0;
        position <= '0;
      end
    end
  end

endmodule

// File: rtl/core/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted table of signed words with a binary search over a configured window.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): req_type selects a load, which writes
// value at entry_index, or a search for the key in value. Output channel
// (out_valid / out_stall) returns one transaction per input: found and the
// matched position, the written index for a load, or zero when not found.
// search_low and search_high bound every search window; write them through
// cfg_we / cfg_index / cfg_data while the core is idle.
// A load's result shows in the cycle after acceptance.
// A search makes one table read and compare per cycle in its probe loop:
// up to log2(window)+1 probes, five over sixteen entries. No new input is
// taken until the search's result is loaded and the controller is idle.
// A search over an empty window skips the probe loop and answers like a load.
// The result sits in an output register; a new transaction is accepted only
// while that register is empty or being read, never while a result is held
// back. A search that finishes while the receiver stalls holds its last
// probe until the register frees.
// Reset clears the handshake state and restores the window to indices 0
// through 15; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [stbs_pkg::IDX_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic [stbs_pkg::IDX_W-1:0]        position
);
  import stbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .found       (found),
    .position    (position)
  );

endmodule

// File: rtl/core/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port level checks for the sorted table binary search core.
// ----------------------------------------------------------------------------
module stbs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              req_type,
  input logic [stbs_pkg::IDX_W-1:0]        entry_index,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              found,
  input logic [stbs_pkg::IDX_W-1:0]        position
);
  import stbs_pkg::*;

  // a load answers in the next cycle with its own index
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_LOAD) |=>
      (out_valid && !found && position == $past(entry_index)))
    else $error("load result missing or wrong");

  // no transaction is taken while a result is held back
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output blocked");

  // held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(position)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .entry_index (entry_index),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .position    (position)
);
